### hdl/sha1_byte_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: assertion macros
// Shared concurrent assertion helpers, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication.
`define SBSH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sbsh: same-cycle check failed");

// Next-cycle implication.
`define SBSH_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sbsh: next-cycle check failed");

`endif

### hdl/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: package
// Item and control types and the fixed SHA-1 constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbsh_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = 5;
    localparam int BLOCK_W   = 512;
    localparam int LEN_W     = 64;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [0:NUM_WORDS-1][WORD_W-1:0] chain_t;

    // initial chaining value, h0 first
    localparam chain_t CHAIN_IV = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_R0 = 32'h5A827999;
    localparam word_t K_R1 = 32'h6ED9EBA1;
    localparam word_t K_R2 = 32'h8F1BBCDC;
    localparam word_t K_R3 = 32'hCA62C1D6;

    // round counter and round group boundaries
    localparam logic [6:0] RND_FIRST  = 7'd0;
    localparam logic [6:0] RND_GRP1   = 7'd20;
    localparam logic [6:0] RND_GRP2   = 7'd40;
    localparam logic [6:0] RND_GRP3   = 7'd60;
    localparam logic [6:0] RND_LAST   = 7'd79;

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    localparam logic [2:0] IDX_LAST   = 3'd4;
    localparam logic [2:0] IDX_DONE   = 3'd5;

    typedef enum logic [0:0] {
        OP_BYTE   = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    // commands from the sequencer to the round unit
    typedef struct packed {
        logic             shift_byte;
        logic [7:0]       byte_val;
        logic             shift_len;
        logic [LEN_W-1:0] len_val;
        logic             start;
        logic             restart;
    } rnd_ctl_t;

    typedef struct packed {
        logic busy;
    } rnd_sts_t;

endpackage

`default_nettype wire

### hdl/sbsh_front.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: front end
// Registers each input transaction, classifies it as data or finish and
// hands it to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbsh_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire                 s_kind,
    input  wire  [7:0]          s_data_byte,
    output logic                q_wr_valid,
    input  wire                 q_wr_ready,
    output sbsh_pkg::item_t     q_wr_item
);
    import sbsh_pkg::*;

    logic  hold_valid_reg, hold_valid_next;
    item_t hold_item_reg, hold_item_next;
    item_t in_item;

    always_comb begin
        in_item.op   = s_kind ? OP_FINISH : OP_BYTE;
        in_item.data = s_kind ? ZERO_BYTE : s_data_byte;
    end

    assign s_ready    = !hold_valid_reg || q_wr_ready;
    assign q_wr_valid = hold_valid_reg;
    assign q_wr_item  = hold_item_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_item_next  = hold_item_reg;
        if (hold_valid_reg && q_wr_ready) begin
            hold_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            hold_valid_next = 1'b1;
            hold_item_next  = in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_item_reg <= hold_item_next;
    end

endmodule

`default_nettype wire

### hdl/sbsh_fifo.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: item queue
// Short first-in first-out queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbsh_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 wr_valid,
    output logic                wr_ready,
    input  sbsh_pkg::item_t     wr_item,
    output logic                rd_valid,
    input  wire                 rd_ready,
    output sbsh_pkg::item_t     rd_item
);
    import sbsh_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + ADDR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + ADDR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

### hdl/sbsh_round.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: round unit
// 512-bit block window doubling as the message schedule, one SHA-1 round
// per cycle, and the five chaining words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_byte_stream_hasher_defines.svh"

module sbsh_round (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  sbsh_pkg::rnd_ctl_t  ctl,
    output sbsh_pkg::rnd_sts_t  sts,
    output sbsh_pkg::chain_t    chain
);
    import sbsh_pkg::*;

    logic [BLOCK_W-1:0] win_reg, win_next;
    chain_t             chain_reg, chain_next;
    word_t              a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t              a_next, b_next, c_next, d_next, e_next;
    logic [6:0]         rnd_reg, rnd_next;
    logic               busy_reg, busy_next;
    logic               add_reg, add_next;

    word_t w0, w2, w8, w13, w_mix, w_new;
    word_t f_val, k_val, t_val;
    logic  in_rounds;

    // window word j sits at bits [511-32j -: 32]; word 0 is the current W[t]
    assign w0    = win_reg[511:480];
    assign w2    = win_reg[447:416];
    assign w8    = win_reg[255:224];
    assign w13   = win_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    assign in_rounds = busy_reg && !add_reg;

    always_comb begin
        if (rnd_reg < RND_GRP1) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_R0;
        end else if (rnd_reg < RND_GRP2) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_R1;
        end else if (rnd_reg < RND_GRP3) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_R2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_R3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;
    end

    always_comb begin
        win_next   = win_reg;
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        rnd_next   = rnd_reg;
        busy_next  = busy_reg;
        add_next   = add_reg;

        if (ctl.shift_byte) begin
            win_next = {win_reg[BLOCK_W-9:0], ctl.byte_val};
        end else if (ctl.shift_len) begin
            win_next = {win_reg[BLOCK_W-LEN_W-1:0], ctl.len_val};
        end else if (in_rounds) begin
            win_next = {win_reg[BLOCK_W-WORD_W-1:0], w_new};
        end

        if (ctl.start) begin
            a_next    = chain_reg[0];
            b_next    = chain_reg[1];
            c_next    = chain_reg[2];
            d_next    = chain_reg[3];
            e_next    = chain_reg[4];
            rnd_next  = RND_FIRST;
            busy_next = 1'b1;
            add_next  = 1'b0;
        end else if (in_rounds) begin
            a_next   = t_val;
            b_next   = a_reg;
            c_next   = {b_reg[1:0], b_reg[31:2]};
            d_next   = c_reg;
            e_next   = d_reg;
            rnd_next = rnd_reg + 7'd1;
            if (rnd_reg == RND_LAST) begin
                add_next = 1'b1;
            end
        end else if (add_reg) begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
            busy_next     = 1'b0;
            add_next      = 1'b0;
        end

        if (ctl.restart) begin
            chain_next = CHAIN_IV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= CHAIN_IV;
            busy_reg  <= 1'b0;
            add_reg   <= 1'b0;
            rnd_reg   <= RND_FIRST;
        end else begin
            chain_reg <= chain_next;
            busy_reg  <= busy_next;
            add_reg   <= add_next;
            rnd_reg   <= rnd_next;
        end
        win_reg <= win_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    assign sts.busy = busy_reg;
    assign chain    = chain_reg;

    `SBSH_ASSERT_IMP(a_rnd_in_range, aclk, aresetn, in_rounds, rnd_reg <= RND_LAST)
    `SBSH_ASSERT_NXT(a_add_ends_busy, aclk, aresetn, add_reg, !busy_reg)
    `SBSH_ASSERT_NXT(a_start_arms, aclk, aresetn, ctl.start, busy_reg && rnd_reg == RND_FIRST)

endmodule

`default_nettype wire

### hdl/sbsh_back.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: sequencer
// Feeds bytes into the block window, counts the message length, runs the
// padding, starts compressions and sends the digest words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_byte_stream_hasher_defines.svh"

module sbsh_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_valid,
    output logic                q_pop,
    input  sbsh_pkg::item_t     q_item,
    output sbsh_pkg::rnd_ctl_t  ctl,
    input  sbsh_pkg::rnd_sts_t  sts,
    input  sbsh_pkg::chain_t    chain,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [31:0]         m_digest_word,
    output logic [2:0]          m_word_index,
    output logic                m_last_word
);
    import sbsh_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_CMP_DATA = 6'b000010,
        ST_PAD      = 6'b000100,
        ST_CMP_PAD  = 6'b001000,
        ST_CMP_LEN  = 6'b010000,
        ST_OUT      = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [5:0]       fill_reg, fill_next;
    logic [LEN_W-1:0] bits_reg, bits_next;
    logic [2:0]       idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    word_t            m_word_reg, m_word_next;
    logic [2:0]       m_index_reg, m_index_next;
    logic             m_last_reg, m_last_next;

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        bits_next    = bits_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        m_index_next = m_index_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;
        ctl          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop          = 1'b1;
                    ctl.shift_byte = 1'b1;
                    fill_next      = fill_reg + 6'd1;
                    if (q_item.op == OP_BYTE) begin
                        ctl.byte_val = q_item.data;
                        bits_next    = bits_reg + 64'd8;
                        if (fill_reg == FILL_LAST) begin
                            ctl.start  = 1'b1;
                            state_next = ST_CMP_DATA;
                        end
                    end else begin
                        ctl.byte_val = PAD_BYTE;
                        if (fill_reg == FILL_LAST) begin
                            ctl.start  = 1'b1;
                            state_next = ST_CMP_PAD;
                        end else begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_CMP_DATA: begin
                if (!sts.busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (fill_reg == FILL_LEN) begin
                    ctl.shift_len = 1'b1;
                    ctl.len_val   = bits_reg;
                    ctl.start     = 1'b1;
                    state_next    = ST_CMP_LEN;
                end else begin
                    ctl.shift_byte = 1'b1;
                    ctl.byte_val   = ZERO_BYTE;
                    fill_next      = fill_reg + 6'd1;
                    if (fill_reg == FILL_LAST) begin
                        ctl.start  = 1'b1;
                        state_next = ST_CMP_PAD;
                    end
                end
            end
            ST_CMP_PAD: begin
                if (!sts.busy) begin
                    state_next = ST_PAD;
                end
            end
            ST_CMP_LEN: begin
                if (!sts.busy) begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    if (idx_reg != IDX_DONE) begin
                        m_valid_next = 1'b1;
                        m_word_next  = chain[idx_reg];
                        m_index_next = idx_reg;
                        m_last_next  = (idx_reg == IDX_LAST);
                        idx_next     = idx_reg + 3'd1;
                    end else begin
                        // last word gone: back to a fresh message
                        m_valid_next = 1'b0;
                        ctl.restart  = 1'b1;
                        fill_next    = '0;
                        bits_next    = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            bits_reg    <= bits_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        m_word_reg  <= m_word_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_digest_word = m_word_reg;
    assign m_word_index  = m_index_reg;
    assign m_last_word   = m_last_reg;

    `SBSH_ASSERT_IMP(a_pop_idle, aclk, aresetn, q_pop, state_reg == ST_IDLE)
    `SBSH_ASSERT_IMP(a_out_state, aclk, aresetn, m_valid_reg, state_reg == ST_OUT)
    `SBSH_ASSERT_IMP(a_start_free, aclk, aresetn, ctl.start, !sts.busy)
    `SBSH_ASSERT_IMP(a_start_full, aclk, aresetn, ctl.start, ctl.shift_byte || ctl.shift_len)

endmodule

`default_nettype wire

### hdl/sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Input channel s_*: one transaction per message byte (s_kind = 0) or one
// finish transaction (s_kind = 1, s_data_byte ignored). Output channel m_*:
// five digest words h0..h4 per finish, m_last_word set on h4.
// A byte passes the input register and queue and is then shifted into the
// block window, one byte per cycle while the sequencer is idle. Each full
// block then occupies the single round unit for its 80 rounds and the
// chaining add, while the sequencer takes no bytes; the queue absorbs
// short bursts. A finish pads one zero byte per cycle, runs one or two
// compressions and, once the last one ends, passes through ST_OUT and
// registers h0 in the output register.
// A stalled receiver holds the output register and the sequencer; the queue
// then fills and s_ready drops. Reset (aresetn low, synchronous) empties the
// queue and loads the initial chaining value for a new message.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  wire          s_kind,
    input  wire  [7:0]   s_data_byte,
    output logic         m_valid,
    input  wire          m_ready,
    output logic [31:0]  m_digest_word,
    output logic [2:0]   m_word_index,
    output logic         m_last_word
);
    import sbsh_pkg::*;

    logic     q_wr_valid, q_wr_ready;
    item_t    q_wr_item;
    logic     q_rd_valid, q_rd_ready;
    item_t    q_rd_item;
    rnd_ctl_t rnd_ctl;
    rnd_sts_t rnd_sts;
    chain_t   chain;

    sbsh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .q_wr_valid  (q_wr_valid),
        .q_wr_ready  (q_wr_ready),
        .q_wr_item   (q_wr_item)
    );

    sbsh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_item  (q_wr_item),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_item  (q_rd_item)
    );

    sbsh_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rnd_ctl),
        .sts     (rnd_sts),
        .chain   (chain)
    );

    sbsh_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_rd_valid),
        .q_pop         (q_rd_ready),
        .q_item        (q_rd_item),
        .ctl           (rnd_ctl),
        .sts           (rnd_sts),
        .chain         (chain),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

endmodule

`default_nettype wire

### test/sha1_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher: testbench
// Streams messages of many lengths through the hasher, one byte per input
// transaction and a finish transaction to close each message. A behavioural
// SHA-1 in the bench works out the five digest words of every message, and
// each output transaction is checked against them in order, with random
// idling on both channels and a long output stall that backs up the input.
// ----------------------------------------------------------------------------

module sha1_byte_stream_hasher_tb;

    import sbsh_pkg::*;

    localparam int          ITEMS_TARGET   = 330;
    localparam int          MIN_MESSAGES   = 12;
    localparam int          CYCLE_LIMIT    = 2000000;
    localparam int          SETTLE_CYCLES  = 300;
    localparam int          LONG_HOLD      = 600;
    localparam logic [7:0]  PAD_MARKER     = 8'h80;
    localparam logic [159:0] SHA1_IV = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] ROUND_K0 = 32'h5A827999;
    localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_kind      = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    sha1_byte_stream_hasher uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    always #6 aclk = ~aclk;

    // bench copy of the hashing state
    logic [31:0] chain_h [5];
    logic [7:0]  blk [64];
    int          blk_fill;
    logic [63:0] msg_bits;

    digest_beat_t pending_digest_words [$];

    int  error_count        = 0;
    int  items_sent         = 0;
    int  bytes_sent         = 0;
    int  messages_hashed    = 0;
    int  words_checked      = 0;
    int  input_stall_cycles = 0;
    int  cycle_count        = 0;
    bit  tx_idle_en         = 1'b1;
    bit  rx_idle_en         = 1'b1;
    int  rx_hold_req        = 0;
    int  rx_hold_left       = 0;
    int  rx_gap_left        = 0;

    function automatic void sha1_restart();
        for (int i = 0; i < 5; i++) chain_h[i] = SHA1_IV[159 - 32*i -: 32];
        blk_fill = 0;
        msg_bits = 64'd0;
    endfunction

    function automatic void bench_block_hash();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 80; r++) begin
            x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {x[30:0], x[31]};
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = ROUND_K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = ROUND_K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = ROUND_K2;
            end else begin
                f = b ^ c ^ d;
                k = ROUND_K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
    endfunction

    // absorb one accepted transaction; a finish queues the five digest words
    function automatic void sha1_absorb(op_t op, logic [7:0] data);
        digest_beat_t beat;
        if (op == OP_BYTE) begin
            blk[blk_fill] = data;
            blk_fill++;
            msg_bits += 64'd8;
            if (blk_fill == 64) begin
                bench_block_hash();
                blk_fill = 0;
            end
        end else begin
            blk[blk_fill] = PAD_MARKER;
            blk_fill++;
            // no room left for the length: pad out and take an extra block
            if (blk_fill > 56) begin
                while (blk_fill < 64) begin
                    blk[blk_fill] = 8'h00;
                    blk_fill++;
                end
                bench_block_hash();
                blk_fill = 0;
            end
            while (blk_fill < 56) begin
                blk[blk_fill] = 8'h00;
                blk_fill++;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63 - 8*i -: 8];
            bench_block_hash();
            for (int i = 0; i < 5; i++) begin
                beat.word  = chain_h[i];
                beat.index = 3'(i);
                beat.last  = (i == 4);
                pending_digest_words.push_back(beat);
            end
            sha1_restart();
        end
    endfunction

    // mostly back to back, sometimes short gaps, now and then a long one
    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic int pick_length();
        int r;
        int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 12);
        if (r < 75) return $urandom_range(13, 40);
        if (r < 90) return edges[$urandom_range(0, 7)];
        return $urandom_range(66, 130);
    endfunction

    task automatic send_item(op_t op, logic [7:0] data);
        int gap;
        s_valid     <= 1'b1;
        s_kind      <= op;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sha1_absorb(op, data);
        items_sent++;
        if (op == OP_BYTE) bytes_sent++;
        else messages_hashed++;
        gap = pick_gap(tx_idle_en);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        send_item(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_digests();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_digest_words.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_message();
        send_item(OP_FINISH, 8'h00);
        wait_for_digests();
    endtask

    task automatic test_short_string();
        send_item(OP_BYTE, 8'h61);
        send_item(OP_BYTE, 8'h62);
        send_item(OP_BYTE, 8'h63);
        send_item(OP_FINISH, 8'h00);
        wait_for_digests();
    endtask

    // data bytes at both extremes, and a finish whose byte must be ignored
    task automatic test_byte_extremes();
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h55);
        send_item(OP_BYTE, 8'hAA);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'h80);
        send_item(OP_FINISH, 8'hFF);
        wait_for_digests();
    endtask

    task automatic test_back_to_back_finishes();
        tx_idle_en = 1'b0;
        send_item(OP_FINISH, 8'hA5);
        send_item(OP_FINISH, 8'h5A);
        tx_idle_en = 1'b1;
        wait_for_digests();
    endtask

    // receiver stalls while the sender keeps pushing, so s_ready must drop
    task automatic test_output_backpressure();
        tx_idle_en  = 1'b0;
        rx_hold_req = LONG_HOLD;
        send_message(3);
        for (int i = 0; i < 24; i++) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        send_item(OP_FINISH, 8'($urandom_range(0, 255)));
        tx_idle_en = 1'b1;
        wait_for_digests();
    endtask

    task automatic test_random_messages();
        bit quiet;
        while (items_sent < ITEMS_TARGET || messages_hashed < MIN_MESSAGES) begin
            quiet      = ($urandom_range(0, 3) == 0);
            tx_idle_en = !quiet;
            rx_idle_en = !quiet;
            send_message(pick_length());
            if ($urandom_range(0, 7) == 0) wait_for_digests();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        wait_for_digests();
    endtask

    // receiver: random ready gaps plus an occasional long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            rx_gap_left  = 0;
        end else begin
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left != 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else if (rx_gap_left != 0) begin
                m_ready <= 1'b0;
                rx_gap_left--;
            end else begin
                m_ready     <= 1'b1;
                rx_gap_left  = pick_gap(rx_idle_en);
            end
        end
    end

    // output check against the oldest queued digest word
    always @(posedge aclk) begin
        digest_beat_t want;
        if (aresetn) begin
            if (s_valid && !s_ready) input_stall_cycles++;
            if (m_valid && m_ready) begin
                if (pending_digest_words.size() == 0) begin
                    $display("%0t: unexpected output transaction: word %08h index %0d",
                             $time, m_digest_word, m_word_index);
                    error_count++;
                end else begin
                    want = pending_digest_words.pop_front();
                    words_checked++;
                    if (m_digest_word !== want.word) begin
                        $display("%0t: digest word mismatch: expected %08h, actual %08h",
                                 $time, want.word, m_digest_word);
                        error_count++;
                    end
                    if (m_word_index !== want.index) begin
                        $display("%0t: word index mismatch: expected %0d, actual %0d",
                                 $time, want.index, m_word_index);
                        error_count++;
                    end
                    if (m_last_word !== want.last) begin
                        $display("%0t: last word mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_last_word);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        sha1_restart();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_short_string();
        test_byte_extremes();
        test_back_to_back_finishes();
        test_output_backpressure();
        test_random_messages();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_digest_words.size() != 0) begin
            $display("%0t: %0d digest words never arrived", $time,
                     pending_digest_words.size());
            error_count++;
        end
        $display("Hashed %0d messages from %0d bytes (%0d transactions), %0d digest words checked",
                 messages_hashed, bytes_sent, items_sent, words_checked);
        $display("Input held off for %0d cycles; %0d errors", input_stall_cycles, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/sbsh_pkg.sv
hdl/sbsh_front.sv
hdl/sbsh_fifo.sv
hdl/sbsh_round.sv
hdl/sbsh_back.sv
hdl/sha1_byte_stream_hasher.sv
test/sha1_byte_stream_hasher_tb.sv
